// ===== hdl/sls_pkg.sv =====
// Shared types and constants for the status LED supervisor.
package sls_pkg;

    localparam int unsigned DIM_W     = 8;
    localparam int unsigned SUPPLY_W  = 12;
    localparam int unsigned HALF_W    = 7;
    localparam int unsigned STEP_W    = 7;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned ERR_W     = 16;
    localparam int unsigned MASK_W    = 8;
    localparam int unsigned DUTY_W    = 13;
    localparam int unsigned FADE_W    = 8;
    localparam int unsigned BLINK_W   = 8;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Identify target value that selects every slot.
    localparam logic [SLOT_W-1:0] ALL_SLOTS = 4'd8;

    // Dim levels used by the blink patterns.
    localparam logic [DIM_W-1:0] DIM_LOW   = 8'd1;
    localparam logic [DIM_W-1:0] DIM_ERROR = 8'd100;

    // Duty is 1900 * dim / 100, which is exactly 19 * dim.
    localparam logic [4:0] DUTY_MUL = 5'd19;

    // Register reset values.
    localparam logic [DIM_W-1:0]    IDLE_DIM_RST   = 8'd100;
    localparam logic [SUPPLY_W-1:0] MIN_SUPPLY_RST = 12'd2048;
    localparam logic [HALF_W-1:0]   HALF_RST       = 7'd50;
    localparam logic [STEP_W-1:0]   STEP_RST       = 7'd10;

    typedef enum logic [1:0] {
        REG_IDLE_DIM   = 2'd0,
        REG_MIN_SUPPLY = 2'd1,
        REG_BLINK_HALF = 2'd2,
        REG_FADE_STEP  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        REQ_TICK     = 1'b0,
        REQ_IDENTIFY = 1'b1
    } req_type_t;

    // Input request payload, first field in the highest bits.
    typedef struct packed {
        logic [SUPPLY_W-1:0] supply_level;
        logic [MASK_W-1:0]   pnp_error_mask;
        logic [ERR_W-1:0]    error_bits;
        logic [SLOT_W-1:0]   identify_slot;
    } in_item_t;

    // Result payload, first field in the highest bits.
    typedef struct packed {
        logic [MASK_W-1:0] slot_lit_mask;
        logic [DUTY_W-1:0] led_duty;
        logic [DIM_W-1:0]  dim_level;
        logic [FADE_W-1:0] fade_level;
        logic              supply_ok;
    } out_item_t;

endpackage

// ===== hdl/status_led_supervisor.sv =====
// Status LED and supply supervisor: input register, one-pass update, result register.
// A tick request waits in the input register until the output is free, then the result register raises m_tvalid.
// Throughput: one request per cycle while results are taken; the fade, blink and identify counters update with it.
// An identify request updates the identify state and gives no result.
// Reset (rst_n low, asynchronous) clears both stages, restores register defaults,
// leaves identify idle, and sets the fade level to zero and rising.
module status_led_supervisor #(
    parameter int unsigned IDENT_PERIOD = 150,
    parameter int unsigned IDENT_BLINKS = 2,
    parameter int unsigned SLOT_COUNT   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // identify_slot[3:0], error_bits[19:4], pnp_error_mask[27:20], supply_level[39:28]
    input  logic [sls_pkg::IN_DATA_W-1:0]      s_tdata,
    // req_type[0]
    input  logic                               s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // supply_ok[0], fade_level[8:1], dim_level[16:9], led_duty[29:17],
    // slot_lit_mask[37:30], zero[39:38]
    output logic [sls_pkg::OUT_DATA_W-1:0]     m_tdata,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sls_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sls_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sls_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int unsigned IPOS_W = $clog2(IDENT_PERIOD);
    localparam int unsigned IBLK_W = $clog2(IDENT_BLINKS + 1);
    localparam int unsigned E1     = IDENT_PERIOD * 10 / 100;
    localparam int unsigned B2     = IDENT_PERIOD * 20 / 100;
    localparam int unsigned E2     = IDENT_PERIOD * 50 / 100;

    // Configuration registers.
    logic [sls_pkg::DIM_W-1:0]    idle_dim_reg;
    logic [sls_pkg::SUPPLY_W-1:0] min_supply_reg;
    logic [sls_pkg::HALF_W-1:0]   blink_half_reg;
    logic [sls_pkg::STEP_W-1:0]   fade_step_reg;

    // Pipeline registers.
    logic                         in_valid_reg;
    sls_pkg::req_type_t           in_type_reg;
    sls_pkg::in_item_t            in_data_reg;
    logic                         out_valid_reg;
    sls_pkg::out_item_t           out_data_reg;
    sls_pkg::out_item_t           out_data_next;

    // Supervisor state.
    logic [IPOS_W-1:0]            ipos_reg, ipos_next;
    logic [IBLK_W-1:0]            iblk_reg, iblk_next;
    logic [sls_pkg::SLOT_W-1:0]   itarget_reg, itarget_next;
    logic [sls_pkg::BLINK_W-1:0]  blink_reg, blink_next;
    logic [sls_pkg::FADE_W-1:0]   fade_reg, fade_next;
    logic                         rising_reg, rising_next;

    logic                         is_ident;
    logic                         advance;
    logic                         emit;
    logic                         cfg_write;

    // Combinational helpers for the tick update.
    logic                         active;
    logic                         active_after;
    logic                         rising_sel;
    logic                         any_err;
    logic [sls_pkg::DIM_W-1:0]    dim;
    logic [sls_pkg::BLINK_W-1:0]  blink_inc;
    logic [sls_pkg::BLINK_W-1:0]  half_x2;
    logic [sls_pkg::MASK_W-1:0]   pnp;
    logic [sls_pkg::MASK_W-1:0]   lit;
    logic [sls_pkg::SLOT_W-1:0]   slot_clamped;
    logic [sls_pkg::FADE_W-1:0]   fade_top;

    assign is_ident  = (in_type_reg == sls_pkg::REQ_IDENTIFY);
    // An identify request leaves without a result, so it need not wait for the output.
    assign advance   = in_valid_reg && (is_ident || !out_valid_reg || m_tready);
    assign emit      = advance && !is_ident;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(sls_pkg::OUT_DATA_W - $bits(sls_pkg::out_item_t)){1'b0}}, out_data_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (sls_pkg::reg_idx_t'(paddr[3:2]))
            sls_pkg::REG_IDLE_DIM:   prdata = {24'd0, idle_dim_reg};
            sls_pkg::REG_MIN_SUPPLY: prdata = {20'd0, min_supply_reg};
            sls_pkg::REG_BLINK_HALF: prdata = {25'd0, blink_half_reg};
            sls_pkg::REG_FADE_STEP:  prdata = {25'd0, fade_step_reg};
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        ipos_next    = ipos_reg;
        iblk_next    = iblk_reg;
        itarget_next = itarget_reg;
        blink_next   = blink_reg;
        fade_next    = fade_reg;
        rising_next  = rising_reg;

        active       = (iblk_reg < IBLK_W'(IDENT_BLINKS));
        pnp          = in_data_reg.pnp_error_mask;
        for (int n = 0; n < sls_pkg::MASK_W; n++)
        begin
            if (n >= SLOT_COUNT)
                pnp[n] = 1'b0;
        end
        any_err      = (in_data_reg.error_bits != '0) || (pnp != '0);
        slot_clamped = (in_data_reg.identify_slot > sls_pkg::ALL_SLOTS) ?
                       sls_pkg::ALL_SLOTS : in_data_reg.identify_slot;
        blink_inc    = blink_reg + 8'd1;
        half_x2      = {blink_half_reg, 1'b0};
        fade_top     = 8'd255 - {1'b0, fade_step_reg};

        // Fade direction turns at either end, then the level moves with 8-bit wrap.
        if (fade_reg >= fade_top)
            rising_sel = 1'b0;
        else if (fade_reg <= {1'b0, fade_step_reg})
            rising_sel = 1'b1;
        else
            rising_sel = rising_reg;

        dim = idle_dim_reg;
        if (active)
        begin
            if ((ipos_reg < IPOS_W'(E1)) ||
                ((ipos_reg >= IPOS_W'(B2)) && (ipos_reg < IPOS_W'(E2))))
                dim = sls_pkg::DIM_LOW;
        end
        else if (any_err)
        begin
            dim = ({1'b0, blink_reg} >= {2'b00, blink_half_reg}) ?
                  sls_pkg::DIM_LOW : sls_pkg::DIM_ERROR;
        end

        // The identify pattern has ended once the last period rolls over.
        active_after = active &&
                       !((ipos_reg == IPOS_W'(IDENT_PERIOD - 1)) &&
                         (iblk_reg == IBLK_W'(IDENT_BLINKS - 1)));

        lit = '0;
        for (int n = 0; n < sls_pkg::MASK_W; n++)
        begin
            if (n < SLOT_COUNT)
            begin
                if (active_after)
                    lit[n] = (itarget_reg == sls_pkg::SLOT_W'(n)) ||
                             (itarget_reg == sls_pkg::ALL_SLOTS);
                else
                    lit[n] = pnp[n] || in_data_reg.error_bits[n];
            end
        end

        out_data_next.supply_ok     = (in_data_reg.supply_level >= min_supply_reg);
        out_data_next.fade_level    = rising_sel ? fade_reg + {1'b0, fade_step_reg} :
                                                   fade_reg - {1'b0, fade_step_reg};
        out_data_next.dim_level     = dim;
        out_data_next.led_duty      = sls_pkg::DUTY_W'({5'd0, dim} * sls_pkg::DUTY_MUL);
        out_data_next.slot_lit_mask = lit;

        if (advance)
        begin
            if (is_ident)
            begin
                ipos_next    = '0;
                iblk_next    = '0;
                itarget_next = slot_clamped;
            end
            else
            begin
                rising_next = rising_sel;
                fade_next   = out_data_next.fade_level;
                if (active)
                begin
                    if (ipos_reg == IPOS_W'(IDENT_PERIOD - 1))
                    begin
                        ipos_next = '0;
                        iblk_next = iblk_reg + 1'b1;
                    end
                    else
                    begin
                        ipos_next = ipos_reg + 1'b1;
                    end
                    if (!active_after)
                        itarget_next = sls_pkg::ALL_SLOTS;
                end
                else if (any_err)
                begin
                    blink_next = (blink_inc > half_x2) ? '0 : blink_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_type_reg    <= sls_pkg::REQ_TICK;
            out_valid_reg  <= 1'b0;
            ipos_reg       <= '0;
            iblk_reg       <= IBLK_W'(IDENT_BLINKS);
            itarget_reg    <= sls_pkg::ALL_SLOTS;
            blink_reg      <= '0;
            fade_reg       <= '0;
            rising_reg     <= 1'b1;
            idle_dim_reg   <= sls_pkg::IDLE_DIM_RST;
            min_supply_reg <= sls_pkg::MIN_SUPPLY_RST;
            blink_half_reg <= sls_pkg::HALF_RST;
            fade_step_reg  <= sls_pkg::STEP_RST;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_type_reg  <= sls_pkg::req_type_t'(s_tuser);
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            ipos_reg    <= ipos_next;
            iblk_reg    <= iblk_next;
            itarget_reg <= itarget_next;
            blink_reg   <= blink_next;
            fade_reg    <= fade_next;
            rising_reg  <= rising_next;

            if (cfg_write)
            begin
                unique case (sls_pkg::reg_idx_t'(paddr[3:2]))
                    sls_pkg::REG_IDLE_DIM:   idle_dim_reg   <= pwdata[sls_pkg::DIM_W-1:0];
                    sls_pkg::REG_MIN_SUPPLY: min_supply_reg <= pwdata[sls_pkg::SUPPLY_W-1:0];
                    sls_pkg::REG_BLINK_HALF: blink_half_reg <= pwdata[sls_pkg::HALF_W-1:0];
                    sls_pkg::REG_FADE_STEP:  fade_step_reg  <= pwdata[sls_pkg::STEP_W-1:0];
                    default:                 idle_dim_reg   <= idle_dim_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= sls_pkg::in_item_t'(s_tdata);
        if (emit)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== verif/tb_status_led_supervisor.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the status LED and supply supervisor.

class panel_scoreboard;

    localparam int unsigned IDENT_PERIOD = 150;
    localparam int unsigned IDENT_BLINKS = 2;
    localparam int unsigned SLOT_COUNT   = 8;
    localparam int unsigned IDENT_END    = IDENT_PERIOD * IDENT_BLINKS;
    localparam int unsigned FIRST_END    = IDENT_PERIOD * 10 / 100;
    localparam int unsigned SECOND_START = IDENT_PERIOD * 20 / 100;
    localparam int unsigned SECOND_END   = IDENT_PERIOD * 50 / 100;
    localparam logic [7:0]  SLOT_MASK    = 8'((1 << SLOT_COUNT) - 1);

    sls_pkg::out_item_t  panel_q[$];
    int unsigned         mismatch_cnt;

    logic [sls_pkg::DIM_W-1:0]    idle_dim;
    logic [sls_pkg::SUPPLY_W-1:0] min_supply;
    logic [sls_pkg::HALF_W-1:0]   blink_half;
    logic [sls_pkg::STEP_W-1:0]   fade_step;

    int unsigned                  ident_cnt;
    logic [sls_pkg::SLOT_W-1:0]   ident_target;
    logic [sls_pkg::BLINK_W-1:0]  blink_cnt;
    logic [sls_pkg::FADE_W-1:0]   fade_lvl;
    bit                           fade_up;

    function new();
        idle_dim     = sls_pkg::IDLE_DIM_RST;
        min_supply   = sls_pkg::MIN_SUPPLY_RST;
        blink_half   = sls_pkg::HALF_RST;
        fade_step    = sls_pkg::STEP_RST;
        ident_cnt    = IDENT_END;
        ident_target = sls_pkg::ALL_SLOTS;
        blink_cnt    = '0;
        fade_lvl     = '0;
        fade_up      = 1'b1;
        mismatch_cnt = 0;
    endfunction

    function void fail_note(string what, string detail);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("[%0t] %s:%s", $time, what, detail);
        end
    endfunction

    function void set_reg(sls_pkg::reg_idx_t idx, logic [31:0] val);
        case (idx)
            sls_pkg::REG_IDLE_DIM:   idle_dim   = val[sls_pkg::DIM_W-1:0];
            sls_pkg::REG_MIN_SUPPLY: min_supply = val[sls_pkg::SUPPLY_W-1:0];
            sls_pkg::REG_BLINK_HALF: blink_half = val[sls_pkg::HALF_W-1:0];
            default:                 fade_step  = val[sls_pkg::STEP_W-1:0];
        endcase
    endfunction

    function logic [31:0] reg_value(sls_pkg::reg_idx_t idx);
        case (idx)
            sls_pkg::REG_IDLE_DIM:   return 32'(idle_dim);
            sls_pkg::REG_MIN_SUPPLY: return 32'(min_supply);
            sls_pkg::REG_BLINK_HALF: return 32'(blink_half);
            default:                 return 32'(fade_step);
        endcase
    endfunction

    // Advances the supervisor state for one accepted request and, for a tick, queues the panel result.
    function void note_request(sls_pkg::req_type_t rt, sls_pkg::in_item_t it);
        sls_pkg::out_item_t        res;
        logic [sls_pkg::DIM_W-1:0] dim;
        logic [7:0]                lit;
        logic [7:0]                pnp;
        bit                        identifying;
        int unsigned               pos;
        int                        n;
        if (rt == sls_pkg::REQ_IDENTIFY)
        begin
            ident_cnt    = 0;
            ident_target = (it.identify_slot > sls_pkg::ALL_SLOTS) ?
                           sls_pkg::ALL_SLOTS : it.identify_slot;
            return;
        end
        pnp = it.pnp_error_mask & SLOT_MASK;

        if (int'(fade_lvl) >= 255 - int'(fade_step))
        begin
            fade_up = 1'b0;
        end
        else if (int'(fade_lvl) <= int'(fade_step))
        begin
            fade_up = 1'b1;
        end
        fade_lvl = fade_up ? fade_lvl + fade_step : fade_lvl - fade_step;

        if (ident_cnt < IDENT_END)
        begin
            pos = ident_cnt % IDENT_PERIOD;
            if (pos < FIRST_END || (pos >= SECOND_START && pos < SECOND_END))
            begin
                dim = sls_pkg::DIM_LOW;
            end
            else
            begin
                dim = idle_dim;
            end
            ident_cnt++;
            if (ident_cnt == IDENT_END)
            begin
                ident_target = sls_pkg::ALL_SLOTS;
            end
        end
        else if (it.error_bits != 0 || pnp != 0)
        begin
            dim = (blink_cnt >= blink_half) ? sls_pkg::DIM_LOW : sls_pkg::DIM_ERROR;
            blink_cnt = blink_cnt + 8'd1;
            if (int'(blink_cnt) > 2 * int'(blink_half))
            begin
                blink_cnt = '0;
            end
        end
        else
        begin
            dim = idle_dim;
        end

        identifying = ident_cnt < IDENT_END;
        lit = '0;
        for (n = 0; n < SLOT_COUNT; n++)
        begin
            if (identifying)
            begin
                lit[n] = (ident_target == n) || (ident_target == sls_pkg::ALL_SLOTS);
            end
            else
            begin
                lit[n] = pnp[n] | it.error_bits[n];
            end
        end

        res.supply_ok     = it.supply_level >= min_supply;
        res.fade_level    = fade_lvl;
        res.dim_level     = dim;
        res.led_duty      = sls_pkg::DUTY_W'(1900 * int'(dim) / 100);
        res.slot_lit_mask = lit & SLOT_MASK;
        panel_q.push_back(res);
    endfunction

    function void check_panel(sls_pkg::out_item_t got);
        sls_pkg::out_item_t exp_res;
        string              diffs;
        if (panel_q.size() == 0)
        begin
            fail_note("panel result with no pending tick", $sformatf(" got %h", got));
            return;
        end
        exp_res = panel_q.pop_front();
        diffs = "";
        if (got.supply_ok !== exp_res.supply_ok)
        begin
            diffs = {diffs, $sformatf(" supply_ok exp %0d got %0d",
                                      exp_res.supply_ok, got.supply_ok)};
        end
        if (got.fade_level !== exp_res.fade_level)
        begin
            diffs = {diffs, $sformatf(" fade_level exp %0d got %0d",
                                      exp_res.fade_level, got.fade_level)};
        end
        if (got.dim_level !== exp_res.dim_level)
        begin
            diffs = {diffs, $sformatf(" dim_level exp %0d got %0d",
                                      exp_res.dim_level, got.dim_level)};
        end
        if (got.led_duty !== exp_res.led_duty)
        begin
            diffs = {diffs, $sformatf(" led_duty exp %0d got %0d",
                                      exp_res.led_duty, got.led_duty)};
        end
        if (got.slot_lit_mask !== exp_res.slot_lit_mask)
        begin
            diffs = {diffs, $sformatf(" slot_lit_mask exp %h got %h",
                                      exp_res.slot_lit_mask, got.slot_lit_mask)};
        end
        if (diffs != "")
        begin
            fail_note("panel result mismatch", diffs);
        end
    endfunction

endclass

module tb_status_led_supervisor;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned SEG_ITEMS   = 117;

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [sls_pkg::IN_DATA_W-1:0]     s_tdata  = '0;
    logic                              s_tuser  = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [sls_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [sls_pkg::APB_ADDR_W-1:0]    paddr    = '0;
    logic [sls_pkg::APB_DATA_W-1:0]    pwdata   = '0;
    logic [sls_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;

    panel_scoreboard sb;
    int unsigned     send_idle_pct = 34;
    int unsigned     recv_idle_pct = 86;
    int unsigned     hold_cycles   = 0;
    int unsigned     cycle_cnt;

    status_led_supervisor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("** status_led_supervisor: FAILED **");
        $finish;
    end

    // Result side: checks accepted results and decides tready for the next edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                sb.check_panel(
                    sls_pkg::out_item_t'(m_tdata[$bits(sls_pkg::out_item_t)-1:0]));
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic sls_pkg::in_item_t make_item(int slot, int err, int pnp, int supply);
        sls_pkg::in_item_t it;
        it.identify_slot  = sls_pkg::SLOT_W'(slot);
        it.error_bits     = sls_pkg::ERR_W'(err);
        it.pnp_error_mask = sls_pkg::MASK_W'(pnp);
        it.supply_level   = sls_pkg::SUPPLY_W'(supply);
        return it;
    endfunction

    function automatic int pick_value(int lo, int hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return int'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic send_item(sls_pkg::req_type_t rt, sls_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= rt;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_request(rt, it);
    endtask

    // Stops offering requests and waits until every pending result has come back or the drain limit is reached.
    task automatic drain(int unsigned settle);
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sb.panel_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.panel_q.size() != 0)
        begin
            sb.fail_note("results never arrived", $sformatf(" %0d pending", sb.panel_q.size()));
            sb.panel_q.delete();
        end
        repeat (settle) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic write_reg(sls_pkg::reg_idx_t idx, int val);
        logic [31:0] want;
        sb.set_reg(idx, val);
        want = sb.reg_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            sb.fail_note("register readback", $sformatf(" reg %0d exp %h got %h",
                                                          idx, want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(int unsigned count, bit with_identify);
        sls_pkg::in_item_t  it;
        sls_pkg::req_type_t rt;
        int                 lvl;
        repeat (count)
        begin
            rt = (with_identify && $urandom_range(149) == 0) ?
                 sls_pkg::REQ_IDENTIFY : sls_pkg::REQ_TICK;
            if ($urandom_range(9) == 0)
            begin
                it.identify_slot = sls_pkg::SLOT_W'($urandom_range(15));
            end
            else
            begin
                it.identify_slot = sls_pkg::SLOT_W'($urandom_range(8));
            end
            if ($urandom_range(9) < 4)
            begin
                it.error_bits     = '0;
                it.pnp_error_mask = '0;
            end
            else
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        it.error_bits     = sls_pkg::ERR_W'($urandom);
                        it.pnp_error_mask = sls_pkg::MASK_W'($urandom);
                    end
                    1:
                    begin
                        it.error_bits     = sls_pkg::ERR_W'(1) << $urandom_range(15);
                        it.pnp_error_mask = '0;
                    end
                    default:
                    begin
                        it.error_bits     = '0;
                        it.pnp_error_mask = sls_pkg::MASK_W'(1) << $urandom_range(7);
                    end
                endcase
            end
            // Some samples sit at or next to the threshold.
            if ($urandom_range(3) == 0)
            begin
                lvl = int'(sb.min_supply) + int'($urandom_range(2)) - 1;
                lvl = (lvl < 0) ? 0 : (lvl > 4095) ? 4095 : lvl;
            end
            else
            begin
                lvl = int'($urandom_range(4095));
            end
            it.supply_level = sls_pkg::SUPPLY_W'(lvl);
            send_item(rt, it);
        end
    endtask

    initial
    begin
        int seg;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Supply threshold edges and error blink with the reset register values.
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 0));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 4095));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 2048));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 2047));
        send_item(sls_pkg::REQ_TICK, make_item(0, 16'hFFFF, 0, 2048));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 8'hFF, 1000));
        send_item(sls_pkg::REQ_TICK, make_item(0, 16'hFF00, 0, 3000));
        drain(SETTLE);

        // Zero registers freeze the fade and hold the blink at the low level.
        write_reg(sls_pkg::REG_IDLE_DIM, 0);
        write_reg(sls_pkg::REG_MIN_SUPPLY, 0);
        write_reg(sls_pkg::REG_BLINK_HALF, 0);
        write_reg(sls_pkg::REG_FADE_STEP, 0);
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 0));
        send_item(sls_pkg::REQ_TICK, make_item(0, 1, 0, 5));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 8'h80, 4095));
        drain(SETTLE);

        write_reg(sls_pkg::REG_IDLE_DIM, 255);
        write_reg(sls_pkg::REG_MIN_SUPPLY, 4095);
        write_reg(sls_pkg::REG_BLINK_HALF, 127);
        write_reg(sls_pkg::REG_FADE_STEP, 127);
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 4095));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 4094));
        send_item(sls_pkg::REQ_TICK, make_item(0, 16'h8000, 0, 4095));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 0));

        // Identify requests, each restarting the pattern, including slots above all-slots.
        send_item(sls_pkg::REQ_IDENTIFY, make_item(0, 0, 0, 0));
        send_item(sls_pkg::REQ_TICK, make_item(0, 16'h00FF, 0, 4095));
        send_item(sls_pkg::REQ_IDENTIFY, make_item(7, 16'hFFFF, 8'hFF, 4095));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 100));
        send_item(sls_pkg::REQ_IDENTIFY, make_item(15, 0, 0, 0));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 100));
        send_item(sls_pkg::REQ_IDENTIFY, make_item(8, 0, 0, 0));
        send_item(sls_pkg::REQ_TICK, make_item(0, 16'hAAAA, 8'h55, 4095));
        send_item(sls_pkg::REQ_IDENTIFY, make_item(9, 0, 0, 0));
        send_item(sls_pkg::REQ_TICK, make_item(0, 0, 0, 4095));
        send_item(sls_pkg::REQ_TICK, make_item(0, 16'h0001, 0, 0));

        for (seg = 0; seg < 6; seg++)
        begin
            send_idle_pct = (seg < 2) ? 34 : (seg < 4) ? 86 : 0;
            recv_idle_pct = (seg < 2) ? 86 : (seg < 4) ? 34 : 0;
            drain(SETTLE);
            write_reg(sls_pkg::REG_IDLE_DIM, pick_value(0, 255));
            write_reg(sls_pkg::REG_MIN_SUPPLY, pick_value(0, 4095));
            write_reg(sls_pkg::REG_BLINK_HALF, pick_value(1, 127));
            write_reg(sls_pkg::REG_FADE_STEP, pick_value(1, 127));
            // A long result stall while requests keep coming fills the pipeline.
            if (seg == 4)
            begin
                hold_cycles = 150;
            end
            send_random(SEG_ITEMS, seg >= 3);
        end
        drain(SETTLE);

        if (sb.mismatch_cnt == 0)
        begin
            $display("** status_led_supervisor: PASSED **");
        end
        else
        begin
            $display("** status_led_supervisor: FAILED **");
        end
        $finish;
    end

endmodule

// ===== status_led_supervisor.f =====
hdl/sls_pkg.sv
hdl/status_led_supervisor.sv
verif/tb_status_led_supervisor.sv
